// ===== rtl/core/i2cw_pkg.sv =====
// shared types and constants of the i2c master write sequencer
`default_nettype none

package i2cw_pkg;

  localparam int unsigned AddrWidth    = 8;
  localparam int unsigned TicksWidth   = 16;
  localparam int unsigned CfgDataWidth = 16;
  localparam int unsigned CfgIdxWidth  = 1;

  // configuration register indexes
  localparam logic [CfgIdxWidth-1:0] CFG_DEVICE_WRITE_ADDRESS = 1'd0;
  localparam logic [CfgIdxWidth-1:0] CFG_PHASE_TICKS          = 1'd1;

  // configuration reset values
  localparam logic [AddrWidth-1:0]  DeviceAddrReset = 8'h20;
  localparam logic [TicksWidth-1:0] PhaseTicksReset = 16'd5;

  typedef struct packed {
    logic       byte_offered;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
    logic       sda_sampled;
  } in_item_t;

  typedef struct packed {
    logic clock_line;
    logic data_line;
    logic ready_for_byte;
    logic nack_seen;
    logic transfer_done;
  } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/i2cw_if.sv =====
// valid/ready channel interfaces for input and result items
`default_nettype none

interface i2cw_in_if
  import i2cw_pkg::*;
();
  logic     valid;
  logic     ready;
  in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface i2cw_out_if
  import i2cw_pkg::*;
();
  logic      valid;
  logic      ready;
  out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/i2cw_seq.sv =====
// bus phase sequencer: state registers and the per-tick step logic
`default_nettype none

module i2cw_seq
  import i2cw_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  step_i,
  input  wire in_item_t              item_i,
  input  wire logic [AddrWidth-1:0]  dev_addr_i,
  input  wire logic [TicksWidth-1:0] phase_ticks_i,
  output      out_item_t             result_o
);

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_START_A  = 4'd1,
    PH_START_B  = 4'd2,
    PH_BIT_LOW  = 4'd3,
    PH_BIT_HIGH = 4'd4,
    PH_ACK_LOW  = 4'd5,
    PH_ACK_HIGH = 4'd6,
    PH_WAIT     = 4'd7,
    PH_STOP_A   = 4'd8,
    PH_STOP_B   = 4'd9
  } phase_e;

  phase_e                phase_q, phase_d;
  logic [3:0]            bit_cnt_q, bit_cnt_d;
  logic [7:0]            shift_q, shift_d;
  logic [TicksWidth-1:0] tick_q, tick_d;
  logic                  pend_last_q, pend_last_d;
  logic                  abort_q, abort_d;

  logic [TicksWidth-1:0] len;
  logic                  elapsed;
  logic                  ready;
  logic                  done;

  // zero length phase counts as one tick
  assign len     = (phase_ticks_i == '0) ? TicksWidth'(1) : phase_ticks_i;
  assign elapsed = ({1'b0, tick_q} + (TicksWidth + 1)'(1)) >= {1'b0, len};

  always_comb begin
    phase_d     = phase_q;
    bit_cnt_d   = bit_cnt_q;
    shift_d     = shift_q;
    tick_d      = elapsed ? '0 : tick_q + TicksWidth'(1);
    pend_last_d = pend_last_q;
    abort_d     = abort_q;
    ready       = 1'b0;
    done        = 1'b0;
    unique case (phase_q)
      PH_IDLE: begin
        tick_d = tick_q;
        if (item_i.byte_offered) begin
          if (item_i.first_byte) begin
            abort_d = 1'b0;
            phase_d = PH_START_A;
            tick_d  = '0;
          end else begin
            // stray byte, drop it
            ready = 1'b1;
          end
        end
      end
      PH_START_A: if (elapsed) phase_d = PH_START_B;
      PH_START_B: begin
        if (elapsed) begin
          shift_d   = dev_addr_i;
          bit_cnt_d = 4'd8;
          phase_d   = PH_BIT_LOW;
        end
      end
      PH_BIT_LOW: if (elapsed) phase_d = PH_BIT_HIGH;
      PH_BIT_HIGH: begin
        if (elapsed) begin
          if (bit_cnt_q[2:0] == 3'b111) begin
            phase_d = PH_ACK_LOW;
          end else begin
            shift_d   = {shift_q[6:0], 1'b0};
            bit_cnt_d = bit_cnt_q + 4'd1;
            phase_d   = PH_BIT_LOW;
          end
        end
      end
      PH_ACK_LOW: if (elapsed) phase_d = PH_ACK_HIGH;
      PH_ACK_HIGH: begin
        if (elapsed) begin
          if (item_i.sda_sampled) begin
            abort_d = 1'b1;
            phase_d = PH_STOP_A;
          end else if (!bit_cnt_q[3] && pend_last_q) begin
            phase_d = PH_STOP_A;
          end else begin
            phase_d = PH_WAIT;
          end
        end
      end
      PH_WAIT: begin
        tick_d = tick_q;
        if (item_i.byte_offered) begin
          ready       = 1'b1;
          shift_d     = item_i.data_byte;
          pend_last_d = item_i.last_byte;
          bit_cnt_d   = '0;
          phase_d     = PH_BIT_LOW;
          tick_d      = '0;
        end
      end
      PH_STOP_A: if (elapsed) phase_d = PH_STOP_B;
      PH_STOP_B: begin
        if (elapsed) begin
          done    = 1'b1;
          phase_d = PH_IDLE;
        end
      end
      default: begin
        phase_d = PH_IDLE;
        tick_d  = '0;
      end
    endcase
  end

  // line levels of the phase being entered
  always_comb begin
    result_o.ready_for_byte = ready;
    result_o.nack_seen      = abort_d;
    result_o.transfer_done  = done;
    unique case (phase_d)
      PH_START_B:  begin result_o.clock_line = 1'b1; result_o.data_line = 1'b0;       end
      PH_BIT_LOW:  begin result_o.clock_line = 1'b0; result_o.data_line = shift_d[7]; end
      PH_BIT_HIGH: begin result_o.clock_line = 1'b1; result_o.data_line = shift_d[7]; end
      PH_ACK_LOW:  begin result_o.clock_line = 1'b0; result_o.data_line = 1'b1;       end
      PH_WAIT:     begin result_o.clock_line = 1'b0; result_o.data_line = 1'b1;       end
      PH_STOP_A:   begin result_o.clock_line = 1'b0; result_o.data_line = 1'b0;       end
      PH_STOP_B:   begin result_o.clock_line = 1'b1; result_o.data_line = 1'b0;       end
      default:     begin result_o.clock_line = 1'b1; result_o.data_line = 1'b1;       end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      bit_cnt_q   <= '0;
      shift_q     <= '0;
      tick_q      <= '0;
      pend_last_q <= 1'b0;
      abort_q     <= 1'b0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      bit_cnt_q   <= bit_cnt_d;
      shift_q     <= shift_d;
      tick_q      <= tick_d;
      pend_last_q <= pend_last_d;
      abort_q     <= abort_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/i2c_master_write_sequencer.sv =====
// top level of the i2c master write sequencer
//
// Steps an i2c master write transfer one time tick per input item: start
// condition, the configured address byte MSB first with its ACK slot, then
// data bytes with their own ACK slots, then a stop condition. A NACK sends
// an immediate stop and sets nack_seen until the next first-marked byte
// opens a transfer. Each input item yields exactly one result item holding
// the SCL/SDA levels of the phase entered on that tick plus the byte,
// nack and done flags. Throughput is one item per clock while the result
// side takes them; each is held in the result register behind the step logic.
// The input side stays ready while the result register is empty or being
// drained in the same cycle. Configuration writes take effect at once; the
// address register is sampled when the start condition ends.
`default_nettype none

module i2c_master_write_sequencer
  import i2cw_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  // configuration write port
  input  wire logic                    cfg_we_i,
  input  wire logic [CfgIdxWidth-1:0]  cfg_idx_i,
  input  wire logic [CfgDataWidth-1:0] cfg_wdata_i,
  // item channels
  i2cw_in_if.sink                      in_i,
  i2cw_out_if.source                   out_o
);

  // configuration registers
  logic [AddrWidth-1:0]  dev_addr_q;
  logic [TicksWidth-1:0] phase_ticks_q;

  // result register
  logic      out_valid_q;
  out_item_t out_item_q;

  logic      in_accept;
  out_item_t step_result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q    <= DeviceAddrReset;
      phase_ticks_q <= PhaseTicksReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DEVICE_WRITE_ADDRESS: dev_addr_q    <= cfg_wdata_i[AddrWidth-1:0];
        CFG_PHASE_TICKS:          phase_ticks_q <= cfg_wdata_i[TicksWidth-1:0];
        default: ;
      endcase
    end
  end

  // take a new item whenever the result slot frees up this cycle
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_accept  = in_i.valid && in_i.ready;

  i2cw_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (in_accept),
    .item_i        (in_i.item),
    .dev_addr_i    (dev_addr_q),
    .phase_ticks_i (phase_ticks_q),
    .result_o      (step_result)
  );

  // result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_item_q <= step_result;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.item  = out_item_q;

endmodule

`default_nettype wire
